// ===== rtl/ipv4p_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4p_pkg
// Shared types and constants for the dotted-quad address and port parser.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

	localparam int CH_W    = 8;
	localparam int ACC_W   = 17;
	localparam int ADDR_W  = 32;
	localparam int PORT_W  = 16;
	localparam int OUT_W   = 56;

	localparam logic [ACC_W-1:0]  ACC_MAX      = 17'd131071;
	localparam logic [ACC_W-1:0]  OCTET_MAX    = 17'd255;
	localparam logic [ACC_W-1:0]  PORT_MAX     = 17'd65535;
	localparam logic [ACC_W-1:0]  PORT_MIN     = 17'd1024;
	localparam logic [PORT_W-1:0] DEFAULT_PORT = 16'd1500;

	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		TK_DIGIT,
		TK_DOT,
		TK_COLON,
		TK_END,
		TK_OTHER
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [3:0] digit;
	} token_t;

	typedef enum logic [2:0] {
		PH_OCT0,
		PH_OCT1,
		PH_OCT2,
		PH_OCT3,
		PH_PORT
	} phase_t;

endpackage

// ===== rtl/ipv4p_classify.sv =====
// ----------------------------------------------------------------------------
// ipv4p_classify
// Front end: sorts each incoming character into a parser token.
// ----------------------------------------------------------------------------
module ipv4p_classify (
	input  logic [ipv4p_pkg::CH_W-1:0] ch,
	output ipv4p_pkg::token_t          tok
);
	import ipv4p_pkg::*;

	always_comb begin
		tok.digit = ch[3:0];
		if (ch == CH_NUL) begin
			tok.kind = TK_END;
		end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
			tok.kind = TK_DIGIT;
		end else if (ch == CH_DOT) begin
			tok.kind = TK_DOT;
		end else if (ch == CH_COLON) begin
			tok.kind = TK_COLON;
		end else begin
			tok.kind = TK_OTHER;
		end
	end

endmodule

// ===== rtl/ipv4p_fifo.sv =====
// ----------------------------------------------------------------------------
// ipv4p_fifo
// Short token queue between the classifier and the parser core.
// ----------------------------------------------------------------------------
module ipv4p_fifo #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CNT_FULL) |-> wr_ptr_q == rd_ptr_q)
		else $error("pointers disagree with count");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("push did not advance count");

endmodule

// ===== rtl/ipv4p_exec.sv =====
// ----------------------------------------------------------------------------
// ipv4p_exec
// Back end: runs the parser state on one token per cycle, except while an end token stalls, and holds the result.
// ----------------------------------------------------------------------------
module ipv4p_exec (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ipv4p_pkg::token_t            tok,
	input  logic                         tok_valid,
	output logic                         tok_pop,
	input  logic [ipv4p_pkg::PORT_W-1:0] default_port,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         out_ok,
	output logic [ipv4p_pkg::ADDR_W-1:0] out_addr,
	output logic [ipv4p_pkg::PORT_W-1:0] out_port
);
	import ipv4p_pkg::*;

	localparam int MUL_W = ACC_W + 4;

	phase_t              phase_q, phase_d;
	logic [ACC_W-1:0]    acc_q, acc_d;
	logic                digit_seen_q, digit_seen_d;
	logic [ADDR_W-1:0]   addr_q, addr_d;
	logic                failed_q, failed_d;

	logic                out_valid_q;
	logic                ok_q;
	logic [ADDR_W-1:0]   ip_q;
	logic [PORT_W-1:0]   port_q;

	logic                pop_end;
	logic                octet_ok;
	logic                take_octet;
	logic                set_fail;
	logic [MUL_W-1:0]    acc_ext;
	logic [MUL_W-1:0]    acc_mul;
	logic                good;
	logic [ADDR_W-1:0]   res_addr;
	logic [PORT_W-1:0]   res_port;

	// An end token waits until the output slot frees up; others never stall.
	assign tok_pop  = tok_valid && (tok.kind != TK_END || !out_valid_q || out_ready);
	assign pop_end  = tok_pop && tok.kind == TK_END;
	assign octet_ok = digit_seen_q && acc_q <= OCTET_MAX;

	assign acc_ext = MUL_W'(acc_q);
	assign acc_mul = (acc_ext << 3) + (acc_ext << 1) + MUL_W'(tok.digit);

	// Decide per token what the parser does
	always_comb begin
		take_octet = 1'b0;
		set_fail   = 1'b0;
		if (tok_pop && !failed_q) begin
			case (tok.kind)
				TK_DIGIT: ;
				TK_DOT: begin
					if ((phase_q == PH_OCT0 || phase_q == PH_OCT1 || phase_q == PH_OCT2)
						&& octet_ok) begin
						take_octet = 1'b1;
					end else begin
						set_fail = 1'b1;
					end
				end
				TK_COLON: begin
					if (phase_q == PH_OCT3 && octet_ok) begin
						take_octet = 1'b1;
					end else begin
						set_fail = 1'b1;
					end
				end
				TK_END: ;
				default: set_fail = 1'b1;
			endcase
		end
	end

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (pop_end) begin
			phase_d = PH_OCT0;
		end else if (take_octet) begin
			unique case (phase_q)
				PH_OCT0: phase_d = PH_OCT1;
				PH_OCT1: phase_d = PH_OCT2;
				PH_OCT2: phase_d = PH_OCT3;
				PH_OCT3: phase_d = PH_PORT;
				PH_PORT: phase_d = PH_PORT;
				default: phase_d = PH_OCT0;
			endcase
		end
	end

	// Datapath next values
	always_comb begin
		acc_d        = acc_q;
		digit_seen_d = digit_seen_q;
		addr_d       = addr_q;
		failed_d     = failed_q;
		if (pop_end) begin
			acc_d        = '0;
			digit_seen_d = 1'b0;
			addr_d       = '0;
			failed_d     = 1'b0;
		end else if (tok_pop && !failed_q && tok.kind == TK_DIGIT) begin
			// saturate rather than wrap
			acc_d        = (acc_mul > MUL_W'(ACC_MAX)) ? ACC_MAX : acc_mul[ACC_W-1:0];
			digit_seen_d = 1'b1;
		end else if (take_octet) begin
			addr_d       = {addr_q[ADDR_W-9:0], acc_q[7:0]};
			acc_d        = '0;
			digit_seen_d = 1'b0;
		end else if (set_fail) begin
			failed_d     = 1'b1;
		end
	end

	// Result of the terminator
	always_comb begin
		good     = 1'b0;
		res_addr = '0;
		res_port = '0;
		if (!failed_q) begin
			if (phase_q == PH_OCT3 && octet_ok) begin
				good     = 1'b1;
				res_addr = {addr_q[ADDR_W-9:0], acc_q[7:0]};
				res_port = default_port;
			end else if (phase_q == PH_PORT && digit_seen_q && acc_q >= PORT_MIN
				&& acc_q <= PORT_MAX) begin
				good     = 1'b1;
				res_addr = addr_q;
				res_port = acc_q[PORT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_OCT0;
			acc_q        <= '0;
			digit_seen_q <= 1'b0;
			addr_q       <= '0;
			failed_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			acc_q        <= acc_d;
			digit_seen_q <= digit_seen_d;
			addr_q       <= addr_d;
			failed_q     <= failed_d;
			if (pop_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_end) begin
			ok_q   <= good;
			ip_q   <= res_addr;
			port_q <= res_port;
		end
	end

	assign out_valid = out_valid_q;
	assign out_ok    = ok_q;
	assign out_addr  = ip_q;
	assign out_port  = port_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !ok_q) |-> (ip_q == '0 && port_q == '0))
		else $error("failed result carries nonzero fields");

	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		pop_end |=> (phase_q == PH_OCT0 && !failed_q && !digit_seen_q && addr_q == '0))
		else $error("parser not rearmed after terminator");

	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!digit_seen_q |-> acc_q == '0)
		else $error("accumulator set without a digit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !pop_end)
		else $error("result overwritten while stalled");

endmodule

// ===== rtl/ipv4_address_port_text_parser.sv =====
// ----------------------------------------------------------------------------
// ipv4_address_port_text_parser
// Parses d.d.d.d or d.d.d.d:port text, one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one ASCII character per transfer; a zero byte ends the
//   string. Only the zero byte produces a result on the m_ side: ok, the
//   32-bit address (first octet in the top byte) and the port. Without a
//   colon the port is the default_port register, written through cfg_wr_en
//   and cfg_wr_data; the user must write it only while the block is idle,
//   which the block itself does not enforce. A failed parse returns ok low
//   with address and port zero. Throughput is one character per cycle while
//   no stall holds the flow: the classifier, the token queue and the parser
//   core each move one token per cycle. A terminator is written into the queue,
//   popped at its head by the core, and the core then loads the output register.
//   Reset clears the queue, rearms the parser and loads default_port with
//   1500. When the receiver stalls, characters keep flowing into the parser
//   until a terminator meets the occupied output register; it then waits at
//   the queue head, and s_tready drops once QUEUE_DEPTH tokens are queued.
// ----------------------------------------------------------------------------
module ipv4_address_port_text_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,     // [7:0] ch
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ipv4p_pkg::OUT_W-1:0]   m_tdata,     // [0] ok, [32:1] ip_address,
	                                                   // [48:33] port_number, rest zero
	input  logic                          cfg_wr_en,
	input  logic [ipv4p_pkg::PORT_W-1:0]  cfg_wr_data
);
	import ipv4p_pkg::*;

	localparam int TOK_W = $bits(token_t);
	localparam int PAD_W = OUT_W - 1 - ADDR_W - PORT_W;

	logic [PORT_W-1:0] default_port_q;
	token_t            in_tok;
	token_t            head_tok;
	logic [TOK_W-1:0]  head_bits;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;
	logic              res_ok;
	logic [ADDR_W-1:0] res_addr;
	logic [PORT_W-1:0] res_port;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_port_q <= DEFAULT_PORT;
		end else if (cfg_wr_en) begin
			default_port_q <= cfg_wr_data;
		end
	end

	ipv4p_classify u_classify (
		.ch  (s_tdata),
		.tok (in_tok)
	);

	assign s_tready = !q_full;

	ipv4p_fifo #(
		.WIDTH (TOK_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid),
		.push_data (in_tok),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (head_bits),
		.not_empty (q_valid)
	);

	assign head_tok = token_t'(head_bits);

	ipv4p_exec u_exec (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok          (head_tok),
		.tok_valid    (q_valid),
		.tok_pop      (q_pop),
		.default_port (default_port_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_ok       (res_ok),
		.out_addr     (res_addr),
		.out_port     (res_port)
	);

	assign m_tdata = {{PAD_W{1'b0}}, res_port, res_addr, res_ok};

endmodule
